### hw/rtl/plbe_pkg.sv
// ============================================================================
// plbe_pkg: shared types and constants of the LED line bit-stream encoder
// Holds the sequencer states, the packer control and status structs, the
// register indexes and the clamping helpers for the timing registers.
// ============================================================================
package plbe_pkg;

    // Fixed word and pixel geometry.
    localparam int OUT_WIDTH  = 32;
    localparam int PIXEL_BITS = 24;
    localparam int CNT_WIDTH  = $clog2(OUT_WIDTH);
    localparam int BIT_IDX_W  = $clog2(PIXEL_BITS);

    // Register port geometry.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;
    localparam int TICK_W     = 5;
    localparam int GAP_W      = 10;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_HIGH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_LOW  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_HIGH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_LOW   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_GAP = 3'd4;

    // Largest usable tick counts.
    localparam logic [TICK_W-1:0] MAX_BIT_TICKS = 5'd16;
    localparam logic [GAP_W-1:0]  MAX_GAP_TICKS = 10'd512;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_GAP_PRE,
        S_HIGH,
        S_LOW,
        S_GAP_POST,
        S_PAD,
        S_ZERO1,
        S_ZERO2,
        S_FLUSH
    } t_state;

    // Control from the sequencer to the tick packer.
    typedef struct packed {
        logic clear;
        logic tick;
        logic level;
    } t_pk_ctrl;

    // Status from the tick packer back to the sequencer.
    typedef struct packed {
        logic                 word_done;
        logic                 empty;
        logic [OUT_WIDTH-1:0] word;
    } t_pk_stat;

    // A bit-timing count of zero is used as one, above sixteen as sixteen.
    function automatic logic [TICK_W-1:0] clamp_bit(input logic [TICK_W-1:0] v);
        logic [TICK_W-1:0] r;
        if (v == '0) begin
            r = TICK_W'(1);
        end else if (v > MAX_BIT_TICKS) begin
            r = MAX_BIT_TICKS;
        end else begin
            r = v;
        end
        return r;
    endfunction

    // The reset gap is limited to 512 ticks.
    function automatic logic [GAP_W-1:0] clamp_gap(input logic [GAP_W-1:0] v);
        logic [GAP_W-1:0] r;
        if (v > MAX_GAP_TICKS) begin
            r = MAX_GAP_TICKS;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

### hw/rtl/plbe_packer.sv
// ============================================================================
// plbe_packer: shared tick shifter of the LED line bit-stream encoder
// Shifts one line level per ticked cycle into a 32-bit word, earliest tick in
// the MSB, and reports the finished word on the cycle its last tick arrives.
// ============================================================================
module plbe_packer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  plbe_pkg::t_pk_ctrl i_ctrl,
    output plbe_pkg::t_pk_stat o_stat
);
    import plbe_pkg::*;

    logic [OUT_WIDTH-1:0] r_word;
    logic [CNT_WIDTH-1:0] r_count;
    logic                 w_last_tick;

    // The incoming tick completes the word when 31 ticks are already held.
    assign w_last_tick = (r_count == CNT_WIDTH'(OUT_WIDTH - 1));

    // Word and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word  <= '0;
            r_count <= '0;
        end else if (i_ctrl.clear) begin
            r_word  <= '0;
            r_count <= '0;
        end else if (i_ctrl.tick) begin
            if (w_last_tick) begin
                r_word  <= '0;
                r_count <= '0;
            end else begin
                r_word  <= {r_word[OUT_WIDTH-2:0], i_ctrl.level};
                r_count <= r_count + CNT_WIDTH'(1);
            end
        end
    end

    // Status back to the sequencer.
    always_comb begin
        o_stat.word_done = i_ctrl.tick && w_last_tick;
        o_stat.empty     = (r_count == '0);
        o_stat.word      = {r_word[OUT_WIDTH-2:0], i_ctrl.level};
    end

endmodule

### hw/rtl/led_pwm_bitstream_encoder_top.sv
// ============================================================================
// led_pwm_bitstream_encoder_top: LED line NRZ bit-stream encoder
// Turns 24-bit GRB pixels into 32-tick line words with programmable high and
// low tick counts per data bit and a reset gap around each frame.
// ============================================================================
//
//  Channel   Handshake                  Payload
//  -------   -------------------------  ---------------------------------------
//  input     i_in_valid / o_in_stall    i_pixel_grb, i_first_pixel, i_last_pixel
//  output    o_out_valid / i_out_stall  o_out_word, o_run_last
//  config    i_cfg_we                   i_cfg_index, i_cfg_data
//
//  The shared tick shifter takes one line tick per cycle while the output
//  register can take a word. A pixel runs through the gap if it is first,
//  its 24 bit times and, if it is last, the gap, zero pad ticks until the
//  partial word is full, and two zero words; the flush then ends the item.
//  The input is stalled for the whole item; a stalled output word pauses
//  the sequencer. Synchronous reset restores the default timing and
//  empties the partial word; there is no clearing pass.
//
module led_pwm_bitstream_encoder_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Register write port
    input  logic                               i_cfg_we,
    input  logic [plbe_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [plbe_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // Pixel input
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [plbe_pkg::PIXEL_BITS-1:0]    i_pixel_grb,
    input  logic                               i_first_pixel,
    input  logic                               i_last_pixel,
    // Line word output
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [plbe_pkg::OUT_WIDTH-1:0]     o_out_word,
    output logic                               o_run_last
);
    import plbe_pkg::*;

    localparam logic [BIT_IDX_W-1:0] LAST_BIT = BIT_IDX_W'(PIXEL_BITS - 1);

    // Timing registers.
    logic [TICK_W-1:0] r_zero_high, r_zero_low, r_one_high, r_one_low;
    logic [GAP_W-1:0]  r_gap;

    // Sequencer state.
    t_state                r_state, n_state;
    logic [GAP_W-1:0]      r_cnt, n_cnt;
    logic [BIT_IDX_W-1:0]  r_bit, n_bit;
    logic [PIXEL_BITS-1:0] r_pix, n_pix;
    logic                  r_last, n_last;

    // Held word and output register.
    logic                  r_hold_valid;
    logic [OUT_WIDTH-1:0]  r_hold_word;
    logic                  r_out_valid;
    logic [OUT_WIDTH-1:0]  r_out_word;
    logic                  r_run_last;

    t_pk_ctrl              w_pk_ctrl;
    t_pk_stat              w_pk_stat;
    logic                  w_step;
    logic                  w_zero_emit;
    logic                  w_flush;
    logic                  w_emit;
    logic [OUT_WIDTH-1:0]  w_emit_word;
    logic                  w_load_out;
    logic                  w_load_last;
    logic [GAP_W-1:0]      w_gap;
    logic [TICK_W-1:0]     w_t0h, w_t0l, w_t1h, w_t1l;

    // Clamped timing values.
    assign w_t0h = clamp_bit(r_zero_high);
    assign w_t0l = clamp_bit(r_zero_low);
    assign w_t1h = clamp_bit(r_one_high);
    assign w_t1l = clamp_bit(r_one_low);
    assign w_gap = clamp_gap(r_gap);

    // Register writes; an unknown index is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_high <= TICK_W'(1);
            r_zero_low  <= TICK_W'(2);
            r_one_high  <= TICK_W'(2);
            r_one_low   <= TICK_W'(1);
            r_gap       <= GAP_W'(120);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ZERO_HIGH: r_zero_high <= i_cfg_data[TICK_W-1:0];
                CFG_ZERO_LOW:  r_zero_low  <= i_cfg_data[TICK_W-1:0];
                CFG_ONE_HIGH:  r_one_high  <= i_cfg_data[TICK_W-1:0];
                CFG_ONE_LOW:   r_one_low   <= i_cfg_data[TICK_W-1:0];
                CFG_RESET_GAP: r_gap       <= i_cfg_data[GAP_W-1:0];
                default: ;
            endcase
        end
    end

    // Outside idle, the sequencer moves only when the output register can take a word.
    assign w_step     = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);

    // Shared tick shifter.
    plbe_packer u_packer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_pk_ctrl),
        .o_stat  (w_pk_stat)
    );

    // Sequencer state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Sequencer counters and pixel shift register.
    always_ff @(posedge i_clk) begin
        r_cnt  <= n_cnt;
        r_bit  <= n_bit;
        r_pix  <= n_pix;
        r_last <= n_last;
    end

    // Next state and tick control.
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_bit       = r_bit;
        n_pix       = r_pix;
        n_last      = r_last;
        w_pk_ctrl   = '0;
        w_zero_emit = 1'b0;
        w_flush     = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_pix  = i_pixel_grb;
                    n_last = i_last_pixel;
                    n_bit  = '0;
                    if (i_first_pixel) begin
                        w_pk_ctrl.clear = 1'b1;
                    end
                    if (i_first_pixel && (w_gap != '0)) begin
                        n_state = S_GAP_PRE;
                        n_cnt   = w_gap;
                    end else begin
                        n_state = S_HIGH;
                        n_cnt   = GAP_W'(i_pixel_grb[PIXEL_BITS-1] ? w_t1h : w_t0h);
                    end
                end
            end
            S_GAP_PRE: begin
                if (w_step) begin
                    w_pk_ctrl.tick = 1'b1;
                    if (r_cnt == GAP_W'(1)) begin
                        n_state = S_HIGH;
                        n_cnt   = GAP_W'(r_pix[PIXEL_BITS-1] ? w_t1h : w_t0h);
                    end else begin
                        n_cnt = r_cnt - GAP_W'(1);
                    end
                end
            end
            S_HIGH: begin
                if (w_step) begin
                    w_pk_ctrl.tick  = 1'b1;
                    w_pk_ctrl.level = 1'b1;
                    if (r_cnt == GAP_W'(1)) begin
                        n_state = S_LOW;
                        n_cnt   = GAP_W'(r_pix[PIXEL_BITS-1] ? w_t1l : w_t0l);
                    end else begin
                        n_cnt = r_cnt - GAP_W'(1);
                    end
                end
            end
            S_LOW: begin
                if (w_step) begin
                    w_pk_ctrl.tick = 1'b1;
                    if (r_cnt != GAP_W'(1)) begin
                        n_cnt = r_cnt - GAP_W'(1);
                    end else if (r_bit != LAST_BIT) begin
                        // Move on to the next data bit.
                        n_pix   = {r_pix[PIXEL_BITS-2:0], 1'b0};
                        n_bit   = r_bit + BIT_IDX_W'(1);
                        n_state = S_HIGH;
                        n_cnt   = GAP_W'(r_pix[PIXEL_BITS-2] ? w_t1h : w_t0h);
                    end else if (!r_last) begin
                        n_state = S_FLUSH;
                    end else if (w_gap != '0) begin
                        n_state = S_GAP_POST;
                        n_cnt   = w_gap;
                    end else begin
                        n_state = S_PAD;
                    end
                end
            end
            S_GAP_POST: begin
                if (w_step) begin
                    w_pk_ctrl.tick = 1'b1;
                    if (r_cnt == GAP_W'(1)) begin
                        n_state = S_PAD;
                    end else begin
                        n_cnt = r_cnt - GAP_W'(1);
                    end
                end
            end
            S_PAD: begin
                // Zero ticks fill the partial word until it goes out.
                if (w_step) begin
                    if (w_pk_stat.empty) begin
                        n_state = S_ZERO1;
                    end else begin
                        w_pk_ctrl.tick = 1'b1;
                        if (w_pk_stat.word_done) begin
                            n_state = S_ZERO1;
                        end
                    end
                end
            end
            S_ZERO1: begin
                if (w_step) begin
                    w_zero_emit = 1'b1;
                    n_state     = S_ZERO2;
                end
            end
            S_ZERO2: begin
                if (w_step) begin
                    w_zero_emit = 1'b1;
                    n_state     = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (w_step) begin
                    w_flush = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // A new word pushes the held one out; the flush sends it as the last word.
    assign w_emit      = w_pk_stat.word_done || w_zero_emit;
    assign w_emit_word = w_pk_stat.word_done ? w_pk_stat.word : '0;
    assign w_load_out  = (w_emit || w_flush) && r_hold_valid;
    assign w_load_last = w_flush;

    // Held word and output control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (w_emit) begin
                r_hold_valid <= 1'b1;
            end else if (w_flush) begin
                r_hold_valid <= 1'b0;
            end
        end
    end

    // Held word and output payload.
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_hold_word <= w_emit_word;
        end
        if (w_load_out) begin
            r_out_word <= r_hold_word;
            r_run_last <= w_load_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;
    assign o_run_last  = r_run_last;

endmodule

### hw/rtl/plbe_checker.sv
// ============================================================================
// plbe_checker: port-level checks of the LED line bit-stream encoder
// Watches the top-level ports for reset behavior, busy time, input hold and
// output hold.
// ============================================================================
module plbe_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               o_in_stall,
    input logic [plbe_pkg::PIXEL_BITS-1:0]    i_pixel_grb,
    input logic                               i_first_pixel,
    input logic                               i_last_pixel,
    input logic                               o_out_valid,
    input logic                               i_out_stall,
    input logic [plbe_pkg::OUT_WIDTH-1:0]     o_out_word,
    input logic                               o_run_last
);
    import plbe_pkg::*;

    // After reset the block is idle with no word pending.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("block not idle after reset");

    // A stalled output word stays valid and unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_out_word) && $stable(o_run_last))
        else $error("stalled output word changed");

    // A stalled input word stays offered and unchanged.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=>
            i_in_valid && $stable(i_pixel_grb) && $stable(i_first_pixel)
            && $stable(i_last_pixel))
        else $error("stalled input word changed");

    // Every pixel keeps the input stalled right after it is accepted.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall ##1 o_in_stall ##1 o_in_stall)
        else $error("input accepted again too soon");

endmodule

bind led_pwm_bitstream_encoder_top plbe_checker u_plbe_checker (.*);

### dv/tb.sv
`timescale 1ns / 100ps
// ============================================================================
// tb: self-checking bench for the LED line bit-stream encoder
// Drives pixel words with random idle and output stall bursts. A scoreboard
// class rebuilds the NRZ tick stream of every accepted pixel and checks each
// line word and its run_last flag in order. Timing registers are reprogrammed
// between phases, covering reset values, clamped extremes and random settings.
// ============================================================================

module tb;
    import plbe_pkg::*;

    localparam int HALF_PERIOD     = 6;
    localparam int RESET_CYCLES    = 11;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int HOLD_CYCLES     = 400;
    localparam int HOLD_AT_WORD    = 300;
    localparam int DRAIN_CYCLES    = 64;
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 50;
    localparam int MAX_PRINTED     = 40;

    // One pixel word as the input channel carries it.
    typedef struct packed {
        logic [PIXEL_BITS-1:0] grb;
        logic                  first_px;
        logic                  last_px;
    } t_pixel_word;

    // Tracks the line encoder: timing registers, the partly filled tick word,
    // and the line words still owed by the block.
    class t_line_scoreboard;
        logic [TICK_W-1:0]    zero_high;
        logic [TICK_W-1:0]    zero_low;
        logic [TICK_W-1:0]    one_high;
        logic [TICK_W-1:0]    one_low;
        logic [GAP_W-1:0]     gap_ticks;
        logic [OUT_WIDTH-1:0] held_ticks;
        int unsigned          held_count;
        logic [OUT_WIDTH-1:0] line_word_q[$];
        bit                   run_last_q[$];
        int unsigned          errors;
        int unsigned          words_checked;

        function new();
            zero_high     = 5'd1;
            zero_low      = 5'd2;
            one_high      = 5'd2;
            one_low       = 5'd1;
            gap_ticks     = 10'd120;
            held_ticks    = '0;
            held_count    = 0;
            errors        = 0;
            words_checked = 0;
        endfunction

        // Register writes keep only the low bits of the data; unknown indexes
        // are dropped.
        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_ZERO_HIGH: zero_high = data[TICK_W-1:0];
                CFG_ZERO_LOW:  zero_low  = data[TICK_W-1:0];
                CFG_ONE_HIGH:  one_high  = data[TICK_W-1:0];
                CFG_ONE_LOW:   one_low   = data[TICK_W-1:0];
                CFG_RESET_GAP: gap_ticks = data[GAP_W-1:0];
                default: ;
            endcase
        endfunction

        // A bit time of zero counts as one tick, anything above 16 as 16.
        function int unsigned bit_ticks(logic [TICK_W-1:0] v);
            if (v == 0) begin
                return 1;
            end
            if (v > 16) begin
                return 16;
            end
            return v;
        endfunction

        function void queue_word(logic [OUT_WIDTH-1:0] w);
            line_word_q = {line_word_q, w};
            run_last_q  = {run_last_q, 1'b0};
        endfunction

        // Shift ticks in at the bottom; a full word leaves with its first
        // tick in the top bit.
        function void shift_ticks(bit level, int unsigned count);
            for (int unsigned n = 0; n < count; n++) begin
                held_ticks = {held_ticks[OUT_WIDTH-2:0], level};
                held_count++;
                if (held_count == OUT_WIDTH) begin
                    queue_word(held_ticks);
                    held_ticks = '0;
                    held_count = 0;
                end
            end
        endfunction

        // Works out the line words of one accepted pixel word.
        function void note_pixel(t_pixel_word px);
            int unsigned t0h;
            int unsigned t0l;
            int unsigned t1h;
            int unsigned t1l;
            int unsigned gap;
            int unsigned queued_before;
            t0h = bit_ticks(zero_high);
            t0l = bit_ticks(zero_low);
            t1h = bit_ticks(one_high);
            t1l = bit_ticks(one_low);
            gap = (gap_ticks > 512) ? 512 : gap_ticks;
            queued_before = line_word_q.size();

            // A fresh frame throws away unfinished ticks before its gap.
            if (px.first_px) begin
                held_ticks = '0;
                held_count = 0;
                shift_ticks(1'b0, gap);
            end
            for (int b = PIXEL_BITS - 1; b >= 0; b--) begin
                if (px.grb[b]) begin
                    shift_ticks(1'b1, t1h);
                    shift_ticks(1'b0, t1l);
                end else begin
                    shift_ticks(1'b1, t0h);
                    shift_ticks(1'b0, t0l);
                end
            end
            // Closing a frame: gap, zero padding if ticks are held, two zero words.
            if (px.last_px) begin
                shift_ticks(1'b0, gap);
                if (held_count != 0) begin
                    queue_word(held_ticks << (OUT_WIDTH - held_count));
                    held_ticks = '0;
                    held_count = 0;
                end
                queue_word('0);
                queue_word('0);
            end
            if (line_word_q.size() > queued_before) begin
                run_last_q[run_last_q.size() - 1] = 1'b1;
            end
        endfunction

        function int unsigned pending();
            return line_word_q.size();
        endfunction

        task report_mismatch(string msg);
            if (errors < MAX_PRINTED) begin
                $display("[%0t] mismatch: %s", $realtime, msg);
            end
            errors++;
        endtask

        // Compares one accepted line word with the oldest one owed.
        task check_word(logic [OUT_WIDTH-1:0] word, logic run_last);
            logic [OUT_WIDTH-1:0] want_word;
            bit                   want_last;
            words_checked++;
            if (line_word_q.size() == 0) begin
                report_mismatch($sformatf("unexpected word %08h run_last %0b", word, run_last));
                return;
            end
            want_word = line_word_q.pop_front();
            want_last = run_last_q.pop_front();
            if (word !== want_word) begin
                report_mismatch($sformatf("word %0d: out_word %08h, want %08h",
                                          words_checked, word, want_word));
            end
            if (run_last !== want_last) begin
                report_mismatch($sformatf("word %0d: run_last %0b, want %0b",
                                          words_checked, run_last, want_last));
            end
        endtask
    endclass

    // Block ports; the inputs are known from time zero.
    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                  i_in_valid    = 1'b0;
    logic                  o_in_stall;
    logic [PIXEL_BITS-1:0] i_pixel_grb   = '0;
    logic                  i_first_pixel = 1'b0;
    logic                  i_last_pixel  = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_stall   = 1'b0;
    logic [OUT_WIDTH-1:0]  o_out_word;
    logic                  o_run_last;

    t_line_scoreboard sb;
    bit               tail_no_idle = 1'b0;
    bit               hold_done    = 1'b0;
    int unsigned      idle_cycles  = 0;
    int unsigned      pixels_sent  = 0;
    int unsigned      frames_sent  = 0;
    int unsigned      timing_sets  = 0;

    led_pwm_bitstream_encoder_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_pixel_grb   (i_pixel_grb),
        .i_first_pixel (i_first_pixel),
        .i_last_pixel  (i_last_pixel),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_word    (o_out_word),
        .o_run_last    (o_run_last)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // Check every line word taken at a rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_word(o_out_word, o_run_last);
        end
    end

    // Watchdog: end the run if no handshake or register write happens for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_we) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[%0t] watchdog: no progress for %0d cycles", $realtime, idle_cycles);
            $display("** led_pwm_bitstream_encoder_top: FAILED **");
            $finish;
        end
    end

    // Output side: random stall bursts with calm stretches, one long hold-off
    // while pixels are offered so the block backs up into its input.
    initial begin
        int  burst;
        bit  calm;
        burst = 0;
        calm  = 1'b0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if ($urandom_range(0, 99) == 0) begin
                calm = ~calm;
            end
            if (!hold_done && sb.words_checked >= HOLD_AT_WORD && i_in_valid) begin
                hold_done = 1'b1;
                burst     = 0;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end else if (burst > 0) begin
                burst--;
                i_out_stall <= 1'b1;
            end else if (!tail_no_idle && !calm && $urandom_range(0, 7) == 0) begin
                burst = $urandom_range(1, 16) - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    function automatic t_pixel_word make_pixel(logic [PIXEL_BITS-1:0] grb, logic f, logic l);
        t_pixel_word px;
        px.grb      = grb;
        px.first_px = f;
        px.last_px  = l;
        return px;
    endfunction

    function automatic logic [PIXEL_BITS-1:0] random_grb();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return {3{8'($urandom)}};
            default: return PIXEL_BITS'($urandom);
        endcase
    endfunction

    // Offer one pixel word, with an optional idle burst ahead of it.
    task automatic send_pixel(t_pixel_word px);
        int gap_len;
        if (!tail_no_idle && $urandom_range(0, 3) == 0) begin
            gap_len = $urandom_range(1, 16);
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap_len - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid    <= 1'b1;
        i_pixel_grb   <= px.grb;
        i_first_pixel <= px.first_px;
        i_last_pixel  <= px.last_px;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_pixel(px);
        pixels_sent++;
        if (px.first_px) begin
            frames_sent++;
        end
    endtask

    // Stop offering pixels and wait until every owed line word has come.
    task automatic finish_phase();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // The enable stays high across back-to-back writes.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
    endtask

    // Tick counts go in the low bits; the spare upper bits carry junk.
    function automatic logic [CFG_DATA_W-1:0] tick_data(int unsigned v);
        logic [CFG_DATA_W-1:0] d;
        d             = CFG_DATA_W'($urandom);
        d[TICK_W-1:0] = TICK_W'(v);
        return d;
    endfunction

    // Program all timing registers, plus one write to an unused index.
    task automatic program_timing(int unsigned t0h, int unsigned t0l,
                                  int unsigned t1h, int unsigned t1l, int unsigned gap);
        write_reg(CFG_ZERO_HIGH, tick_data(t0h));
        write_reg(CFG_ZERO_LOW,  tick_data(t0l));
        write_reg(CFG_ONE_HIGH,  tick_data(t1h));
        write_reg(CFG_RESET_GAP + CFG_IDX_W'($urandom_range(1, 3)), CFG_DATA_W'($urandom));
        write_reg(CFG_ONE_LOW,   tick_data(t1l));
        write_reg(CFG_RESET_GAP, CFG_DATA_W'(gap));
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        timing_sets++;
    endtask

    // Mostly short bit times; now and then zero, sixteen or past the clamp.
    function automatic int unsigned random_bit_time();
        case ($urandom_range(0, 11))
            0:       return 0;
            1:       return 16;
            2:       return $urandom_range(17, 31);
            default: return $urandom_range(1, 4);
        endcase
    endfunction

    function automatic int unsigned random_gap();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return 512;
            2:       return $urandom_range(513, 1023);
            default: return $urandom_range(1, 48);
        endcase
    endfunction

    // Stimulus sequence.
    initial begin
        t_pixel_word px;
        int          count;
        int          frame_len;
        sb = new();
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset timing: plain frame, fresh frame over unfinished ticks,
        // a one-pixel frame and a pixel outside any frame.
        send_pixel(make_pixel(24'h000000, 1'b1, 1'b0));
        send_pixel(make_pixel(24'hFFFFFF, 1'b0, 1'b0));
        send_pixel(make_pixel(24'hAAAAAA, 1'b0, 1'b0));
        send_pixel(make_pixel(24'h555555, 1'b0, 1'b1));
        send_pixel(make_pixel(24'h800001, 1'b1, 1'b1));
        send_pixel(make_pixel(24'h123456, 1'b0, 1'b0));
        send_pixel(make_pixel(24'hFEDCBA, 1'b1, 1'b0));
        send_pixel(make_pixel(24'h0F0F0F, 1'b0, 1'b1));

        // Zero bit times clamp to one tick; an 8-tick gap closes the
        // one-pixel frames on a word boundary, so no padding word.
        finish_phase();
        program_timing(0, 0, 0, 0, 8);
        send_pixel(make_pixel(24'h000000, 1'b1, 1'b1));
        send_pixel(make_pixel(24'hFFFFFF, 1'b1, 1'b1));
        send_pixel(make_pixel(24'h5A5A5A, 1'b1, 1'b0));
        send_pixel(make_pixel(24'hA5A5A5, 1'b0, 1'b1));

        // Bit times past sixteen and a gap past 512.
        finish_phase();
        program_timing(31, 17, 16, 20, 1023);
        send_pixel(make_pixel(24'hFFFFFF, 1'b1, 1'b0));
        send_pixel(make_pixel(24'h000000, 1'b0, 1'b0));
        send_pixel(make_pixel(24'hC3C3C3, 1'b0, 1'b1));
        send_pixel(make_pixel(24'h00FF00, 1'b1, 1'b1));

        // Largest legal mix with a gap just over the limit.
        finish_phase();
        program_timing(16, 1, 1, 16, 513);
        send_pixel(make_pixel(24'h0F0F0F, 1'b1, 1'b1));
        send_pixel(make_pixel(24'h808080, 1'b0, 1'b0));

        // No reset gap at all.
        finish_phase();
        program_timing(2, 3, 4, 5, 0);
        send_pixel(make_pixel(24'h010203, 1'b1, 1'b0));
        send_pixel(make_pixel(24'h040506, 1'b0, 1'b1));
        send_pixel(make_pixel(24'hFFFFFF, 1'b1, 1'b1));

        // Random phases: mostly well-formed frames, some pixels with random
        // flags. The last phase runs without idling.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            finish_phase();
            program_timing(random_bit_time(), random_bit_time(),
                           random_bit_time(), random_bit_time(), random_gap());
            if (ph == RANDOM_PHASES - 1) begin
                tail_no_idle = 1'b1;
            end
            count = 0;
            while (count < ITEMS_PER_PHASE) begin
                if ($urandom_range(0, 4) != 0) begin
                    frame_len = $urandom_range(1, 8);
                    for (int j = 0; j < frame_len; j++) begin
                        px = make_pixel(random_grb(), j == 0, j == frame_len - 1);
                        send_pixel(px);
                        count++;
                    end
                end else begin
                    px = make_pixel(random_grb(), $urandom_range(0, 1), $urandom_range(0, 1));
                    send_pixel(px);
                    count++;
                end
            end
        end

        // Drain, then watch a little longer for stray words.
        finish_phase();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d pixels (%0d frame starts) under %0d timing settings plus reset values.",
                 pixels_sent, frames_sent, timing_sets);
        $display("Checked %0d line words; output hold-off %0s, %0d mismatches.",
                 sb.words_checked, hold_done ? "done" : "missed", sb.errors);
        if (sb.errors == 0) begin
            $display("** led_pwm_bitstream_encoder_top: PASSED **");
        end else begin
            $display("** led_pwm_bitstream_encoder_top: FAILED **");
        end
        $finish;
    end

endmodule

### sim.f
hw/rtl/plbe_pkg.sv
hw/rtl/plbe_packer.sv
hw/rtl/led_pwm_bitstream_encoder_top.sv
hw/rtl/plbe_checker.sv
dv/tb.sv
